// ----- rtl/gamepad_button_event_latch_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Gamepad button event latch: assertion macros
// Short forms for clocked concurrent assertions, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_BUTTON_EVENT_LATCH_UNIT_MACROS_SVH
`define GAMEPAD_BUTTON_EVENT_LATCH_UNIT_MACROS_SVH

// Assertion that is switched off while reset is high
`define GBEL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked across reset
`define GBEL_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/gbel_pkg.sv -----
// ----------------------------------------------------------------------------
// Gamepad button event latch: package
// Widths, entry map, opcodes, flag encodings and the flag store write port.
// ----------------------------------------------------------------------------
package gbel_pkg;

   // Controller slots and entries per slot
   localparam int DEVICES = 4;
   localparam int ENTRIES = 135;
   localparam int DEPTH   = DEVICES * ENTRIES;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   // Field widths
   localparam int OP_W      = 4;
   localparam int DEV_W     = 2;
   localparam int IDX_W     = 8;
   localparam int LEVEL_W   = 16;
   localparam int FLAG_W    = 3;
   localparam int DZ_W      = 16;
   localparam int CSR_IDX_W = 2;
   localparam int DZ_REGS   = 4;
   localparam logic [DZ_W-1:0] DZ_RESET = 16'd3277;

   // Entry map within one slot
   localparam int RAW_BTN_COUNT  = 60;
   localparam int RAW_AXIS_COUNT = 20;
   localparam int RAW_HAT_COUNT  = 5;
   localparam int MAP_BTN_COUNT  = 26;
   localparam int MAP_AXIS_COUNT = 6;
   localparam logic [IDX_W-1:0] RAW_AXIS_BASE = 8'd60;
   localparam logic [IDX_W-1:0] RAW_HAT_BASE  = 8'd80;
   localparam logic [IDX_W-1:0] MAP_BTN_BASE  = 8'd100;
   localparam logic [IDX_W-1:0] MAP_AXIS_BASE = 8'd126;
   localparam logic [IDX_W-1:0] ANY_BUTTON    = 8'd132;
   localparam logic [IDX_W-1:0] ANY_AXIS      = 8'd133;
   localparam logic [IDX_W-1:0] ANY_ALL       = 8'd134;

   // Opcodes; OP_INIT is internal only (post-reset clearing pass)
   localparam logic [OP_W-1:0] OP_TICK    = 4'd0;
   localparam logic [OP_W-1:0] OP_MBTN_DN = 4'd1;
   localparam logic [OP_W-1:0] OP_MBTN_UP = 4'd2;
   localparam logic [OP_W-1:0] OP_MAXIS   = 4'd3;
   localparam logic [OP_W-1:0] OP_RBTN_DN = 4'd4;
   localparam logic [OP_W-1:0] OP_RBTN_UP = 4'd5;
   localparam logic [OP_W-1:0] OP_RAXIS   = 4'd6;
   localparam logic [OP_W-1:0] OP_HAT     = 4'd7;
   localparam logic [OP_W-1:0] OP_QUERY   = 4'd8;
   localparam logic [OP_W-1:0] OP_CLEAR   = 4'd9;
   localparam logic [OP_W-1:0] OP_INIT    = 4'd15;

   // Flag word: bit 0 pressed, bit 1 released, bit 2 held
   localparam logic [FLAG_W-1:0] F_PRESS_SET = 3'b101;
   localparam logic [FLAG_W-1:0] F_KEEP_EDGE = 3'b011;
   localparam logic [FLAG_W-1:0] F_RELEASED  = 3'b010;
   localparam logic [FLAG_W-1:0] F_HELD      = 3'b100;

   // Write port of the flag store
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [FLAG_W-1:0] data;
   } wr_type;

endpackage

// ----- rtl/gbel_flag_store.sv -----
// ----------------------------------------------------------------------------
// Gamepad button event latch: flag store
// One-write one-read synchronous memory of flag words, registered read data.
// ----------------------------------------------------------------------------
module gbel_flag_store import gbel_pkg::*; (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [FLAG_W-1:0] rd_data,
   input  wr_type            wr
);

   logic [FLAG_W-1:0] mem_ff [DEPTH];
   logic [FLAG_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gamepad_button_event_latch_unit.sv -----
// ----------------------------------------------------------------------------
// Gamepad button event latch unit
// Held/pressed/released flags for every entry of every controller slot, kept
// in one flag store and updated by read-modify-write sequences per event word.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    opcode, device, index, level
//   rsp      out        rsp_valid/rsp_ready    held, pressed, released, bad_index
//   csr      in         csr_valid/csr_ready    csr_index, csr_data (deadzones)
//
// Mapped buttons, raw axes and queries touch only their own entry; raw buttons
// and mapped axes also the any-button or any-axis entry and any-all; hats their
// four direction entries, any-button and any-all; a slot clear every entry of
// its slot, a frame tick every entry of the store, a rejected word none. Each
// step reads one entry and, queries apart, writes it back in the next cycle.
// After reset a clearing pass writes all 540 entries, req_ready low. A result
// not taken holds the next word at its end; words are taken only while idle.
// ----------------------------------------------------------------------------
module gamepad_button_event_latch_unit import gbel_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // event words
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic [DEV_W-1:0]          req_device,
   input  logic [IDX_W-1:0]          req_index,
   input  logic signed [LEVEL_W-1:0] req_level,
   // result words
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_held,
   output logic                      rsp_pressed,
   output logic                      rsp_released,
   output logic                      rsp_bad_index,
   // deadzone registers
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [DZ_W-1:0]           csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [2:0] HAT_STEP_ANY_BTN = 3'd4;
   localparam int         MAG_W            = LEVEL_W + 1;
   localparam int         CMP_W            = MAG_W + LEVEL_W;

   // ---------------------------------------------------------------- helpers
   // hat mask to direction bits (0 up, 1 down, 2 left, 3 right)
   function automatic logic [3:0] hat_dirs(input logic [3:0] mask);
      logic [3:0] d;
      case (mask)
         4'd1:    d = 4'b0001;
         4'd4:    d = 4'b0010;
         4'd8:    d = 4'b0100;
         4'd2:    d = 4'b1000;
         4'd9:    d = 4'b0101;
         4'd12:   d = 4'b0110;
         4'd3:    d = 4'b1001;
         4'd6:    d = 4'b1010;
         default: d = 4'b0000;
      endcase
      return d;
   endfunction

   // number of store accesses a word needs
   function automatic logic [CNT_W-1:0] step_count(input logic [OP_W-1:0] op);
      logic [CNT_W-1:0] n;
      case (op)
         OP_MBTN_DN, OP_MBTN_UP, OP_RAXIS, OP_QUERY: n = CNT_W'(1);
         OP_MAXIS, OP_RBTN_DN, OP_RBTN_UP:           n = CNT_W'(3);
         OP_HAT:                                     n = CNT_W'(6);
         OP_CLEAR:                                   n = CNT_W'(ENTRIES);
         OP_TICK, OP_INIT:                           n = CNT_W'(DEPTH);
         default:                                    n = '0;
      endcase
      return n;
   endfunction

   // index range and slot check
   function automatic logic word_bad(input logic [OP_W-1:0] op,
                                     input logic [DEV_W-1:0] dev,
                                     input logic [IDX_W-1:0] idx);
      logic b;
      case (op)
         OP_TICK:                b = 1'b0;
         OP_MBTN_DN, OP_MBTN_UP: b = idx >= IDX_W'(MAP_BTN_COUNT);
         OP_MAXIS:               b = idx >= IDX_W'(MAP_AXIS_COUNT);
         OP_RBTN_DN, OP_RBTN_UP: b = idx >= IDX_W'(RAW_BTN_COUNT);
         OP_RAXIS:               b = idx >= IDX_W'(RAW_AXIS_COUNT);
         OP_HAT:                 b = idx >= IDX_W'(RAW_HAT_COUNT);
         OP_QUERY:               b = idx >= IDX_W'(ENTRIES);
         OP_CLEAR:               b = 1'b0;
         default:                b = 1'b1;
      endcase
      if (op != OP_TICK && int'(dev) >= DEVICES) begin
         b = 1'b1;
      end
      return b;
   endfunction

   // store address of one step of a word
   function automatic logic [ADDR_W-1:0] addr_of(input logic [OP_W-1:0]  op,
                                                 input logic [DEV_W-1:0] dev,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cnt);
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] a;
      logic [IDX_W-1:0]  ent;
      logic [2:0]        s;
      base = ADDR_W'(dev) * ADDR_W'(ENTRIES);
      s    = cnt[2:0];
      case (op)
         OP_MBTN_DN, OP_MBTN_UP: ent = MAP_BTN_BASE + idx;
         OP_MAXIS:
            if (s == 3'd0)      ent = MAP_AXIS_BASE + idx;
            else if (s == 3'd1) ent = ANY_AXIS;
            else                ent = ANY_ALL;
         OP_RBTN_DN, OP_RBTN_UP:
            if (s == 3'd0)      ent = idx;
            else if (s == 3'd1) ent = ANY_BUTTON;
            else                ent = ANY_ALL;
         OP_RAXIS:               ent = RAW_AXIS_BASE + idx;
         OP_HAT:
            if (!s[2])               ent = RAW_HAT_BASE + {idx[IDX_W-3:0], 2'b00}
                                           + IDX_W'(s[1:0]);
            else if (s == HAT_STEP_ANY_BTN) ent = ANY_BUTTON;
            else                     ent = ANY_ALL;
         default:                ent = idx;
      endcase
      case (op)
         OP_TICK, OP_INIT: a = cnt[ADDR_W-1:0];
         OP_CLEAR:         a = base + cnt[ADDR_W-1:0];
         default:          a = base + ADDR_W'(ent);
      endcase
      return a;
   endfunction

   // ---------------------------------------------------------------- state
   logic [1:0]        state_ff;
   logic [OP_W-1:0]   op_ff;
   logic [DEV_W-1:0]  dev_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              moving_ff;
   logic [3:0]        dirs_ff;
   logic              ax_press_ff, ax_release_ff, hat_new_ff, any_rel_ff;
   logic              res_bad_ff;
   logic [FLAG_W-1:0] res_flags_ff;
   logic              mv_ff;
   logic [2:0]        mv_step_ff;
   logic [ADDR_W-1:0] mv_addr_ff;
   logic              rsp_valid_ff;
   logic              rsp_held_ff, rsp_pressed_ff, rsp_released_ff, rsp_bad_ff;
   logic [DZ_W-1:0]   dz_ff [DZ_REGS];

   logic              req_fire, req_bad, rsp_load;
   logic [CNT_W-1:0]  n_cur;
   logic              issue_en;
   logic [CNT_W-1:0]  issue_cnt;
   logic [ADDR_W-1:0] issue_addr;
   logic [FLAG_W-1:0] rd_data, old_flags, new_flags;
   logic              wr_en;
   logic              ax_press_set, ax_release_set, hat_new_set, any_rel_set;
   logic [MAG_W-1:0]  lvl_mag;
   logic [CMP_W-1:0]  lvl_scaled;
   logic [DZ_W+14:0]  dz_scaled;
   logic              moving_in;
   wr_type            wr;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_bad   = word_bad(req_opcode, req_device, req_index);
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign n_cur     = step_count(op_ff);

   // deadzone registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DZ_REGS; i++) begin
            dz_ff[i] <= DZ_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         dz_ff[csr_index] <= csr_data;
      end
   end

   // axis judgement: |level| * 65536 > deadzone * 32767
   always_comb begin
      lvl_mag    = req_level[LEVEL_W-1] ?
                   ({1'b1, {LEVEL_W{1'b0}}} - {1'b0, req_level}) : {1'b0, req_level};
      lvl_scaled = {lvl_mag, {LEVEL_W{1'b0}}};
      dz_scaled  = {dz_ff[req_device], 15'b0} - {15'b0, dz_ff[req_device]};
      moving_in  = lvl_scaled > CMP_W'(dz_scaled);
   end

   // issue side: first step straight from the request, later steps from the word
   always_comb begin
      if (state_ff == ST_IDLE) begin
         issue_en   = req_fire && !req_bad;
         issue_cnt  = '0;
         issue_addr = addr_of(req_opcode, req_device, req_index, '0);
      end else begin
         issue_en   = (state_ff == ST_RUN) && (cnt_ff != n_cur);
         issue_cnt  = cnt_ff;
         issue_addr = addr_of(op_ff, dev_ff, idx_ff, cnt_ff);
      end
   end

   gbel_flag_store u_store (
      .clock   (clock),
      .rd_en   (issue_en),
      .rd_addr (issue_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   // modify side: new flag word for the entry read last cycle
   always_comb begin
      old_flags      = rd_data;
      new_flags      = old_flags;
      wr_en          = mv_ff;
      ax_press_set   = 1'b0;
      ax_release_set = 1'b0;
      hat_new_set    = 1'b0;
      any_rel_set    = 1'b0;
      case (op_ff)
         OP_TICK:                new_flags = old_flags & F_HELD;
         OP_CLEAR, OP_INIT:      new_flags = '0;
         OP_MBTN_DN, OP_RBTN_DN: new_flags = old_flags | F_PRESS_SET;
         OP_MBTN_UP, OP_RBTN_UP: new_flags = (old_flags & F_KEEP_EDGE) | F_RELEASED;
         OP_MAXIS, OP_RAXIS: begin
            if (mv_step_ff == 3'd0) begin
               // own entry decides, aggregates follow
               if (moving_ff && !old_flags[2]) begin
                  new_flags    = old_flags | F_PRESS_SET;
                  ax_press_set = 1'b1;
               end else if (!moving_ff && old_flags[2]) begin
                  new_flags      = (old_flags & F_KEEP_EDGE) | F_RELEASED;
                  ax_release_set = 1'b1;
               end
            end else if (ax_press_ff) begin
               new_flags = old_flags | F_PRESS_SET;
            end else if (ax_release_ff) begin
               new_flags = (old_flags & F_KEEP_EDGE) | F_RELEASED;
            end
         end
         OP_HAT: begin
            if (!mv_step_ff[2]) begin
               // one direction entry
               if (dirs_ff[mv_step_ff[1:0]]) begin
                  if (!old_flags[2]) begin
                     new_flags   = old_flags | F_PRESS_SET;
                     hat_new_set = 1'b1;
                  end
               end else if (old_flags[2]) begin
                  new_flags = (old_flags & F_KEEP_EDGE) | F_RELEASED;
               end
            end else if (mv_step_ff == HAT_STEP_ANY_BTN) begin
               if (hat_new_ff) begin
                  new_flags = old_flags | F_PRESS_SET;
               end else if (dirs_ff == 4'b0000 && old_flags[2]) begin
                  new_flags   = (old_flags & F_KEEP_EDGE) | F_RELEASED;
                  any_rel_set = 1'b1;
               end
            end else if (hat_new_ff) begin
               new_flags = old_flags | F_PRESS_SET;
            end else if (any_rel_ff) begin
               new_flags = (old_flags & F_KEEP_EDGE) | F_RELEASED;
            end
         end
         default: wr_en = 1'b0;
      endcase
   end

   assign wr.en   = wr_en;
   assign wr.addr = mv_addr_ff;
   assign wr.data = new_flags;

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         op_ff    <= OP_INIT;
         cnt_ff   <= '0;
         mv_ff    <= 1'b0;
      end else begin
         mv_ff <= issue_en;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_opcode;
                  cnt_ff   <= CNT_W'(1);
                  state_ff <= req_bad ? ST_DONE : ST_RUN;
               end
            end
            ST_RUN: begin
               if (cnt_ff == n_cur) begin
                  state_ff <= (op_ff == OP_INIT) ? ST_IDLE : ST_DONE;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // word payload, step context and result
   always_ff @(posedge clock) begin
      mv_step_ff <= issue_cnt[2:0];
      mv_addr_ff <= issue_addr;
      if (req_fire) begin
         dev_ff        <= req_device;
         idx_ff        <= req_index;
         moving_ff     <= moving_in;
         dirs_ff       <= hat_dirs(req_level[3:0]);
         res_bad_ff    <= req_bad;
         res_flags_ff  <= '0;
         ax_press_ff   <= 1'b0;
         ax_release_ff <= 1'b0;
         hat_new_ff    <= 1'b0;
         any_rel_ff    <= 1'b0;
      end else if (mv_ff) begin
         ax_press_ff   <= ax_press_ff | ax_press_set;
         ax_release_ff <= ax_release_ff | ax_release_set;
         hat_new_ff    <= hat_new_ff | hat_new_set;
         any_rel_ff    <= any_rel_ff | any_rel_set;
         if (op_ff == OP_QUERY) begin
            res_flags_ff <= rd_data;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_held_ff     <= res_flags_ff[2];
         rsp_pressed_ff  <= res_flags_ff[0];
         rsp_released_ff <= res_flags_ff[1];
         rsp_bad_ff      <= res_bad_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_held      = rsp_held_ff;
   assign rsp_pressed   = rsp_pressed_ff;
   assign rsp_released  = rsp_released_ff;
   assign rsp_bad_index = rsp_bad_ff;

endmodule

// ----- rtl/gbel_checker.sv -----
// ----------------------------------------------------------------------------
// Gamepad button event latch: port checker
// Watches the top level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`include "gamepad_button_event_latch_unit_macros.svh"

module gbel_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_held,
   input logic rsp_pressed,
   input logic rsp_released,
   input logic rsp_bad_index
);

   // a stalled result word holds
   `GBEL_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_held) && $stable(rsp_pressed)
         && $stable(rsp_released) && $stable(rsp_bad_index),
      "result word changed while stalled")

   // the input closes after every accepted word
   `GBEL_ASSERT(a_busy_after_accept, clock, reset,
      req_valid && req_ready |=> !req_ready,
      "input ready right after an accept")

   // rejected words carry no flags
   `GBEL_ASSERT(a_bad_no_flags, clock, reset,
      rsp_valid && rsp_bad_index |-> !(rsp_held || rsp_pressed || rsp_released),
      "flags set on a rejected word")

   // the clearing pass keeps the input closed after reset
   `GBEL_ASSERT_NORST(a_init_closed, clock, reset |=> !req_ready,
      "input ready during clearing pass")

endmodule

bind gamepad_button_event_latch_unit gbel_checker u_gbel_checker (.*);
